### rtl/lbh_pkg.sv
// ----------------------------------------------------------------------------
// lbh_pkg: shared types and constants of the log bucket latency histogram
// Holds the controller/datapath command set, the status bundle, register and
// opcode codes, and the elaboration-time builder of the Q16 power table.
// ----------------------------------------------------------------------------
`default_nettype none

package lbh_pkg;

  // input word opcodes
  localparam logic [1:0] OPC_RECORD = 2'd0;
  localparam logic [1:0] OPC_PCTL   = 2'd1;
  localparam logic [1:0] OPC_READ   = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_LOWEST    = 2'd0;
  localparam logic [1:0] REG_HIGHEST   = 2'd1;
  localparam logic [1:0] REG_PRECISION = 2'd2;

  // precision codes
  localparam logic [1:0] PREC_32 = 2'd2;
  localparam logic [1:0] PREC_64 = 2'd3;

  // reset values of the registers
  localparam logic [63:0] LOWEST_RESET    = 64'd1;
  localparam logic [63:0] HIGHEST_RESET   = 64'd1000000;
  localparam logic [1:0]  PRECISION_RESET = 2'd1;

  // q16 one
  localparam logic [16:0] Q16_ONE = 17'h10000;

  // one command per cycle from controller to datapath
  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLEAR,
    OP_CAPTURE,
    OP_LOG_LO,
    OP_LOG_HI,
    OP_LOG_C,
    OP_SAVE_LO,
    OP_SAVE_HI,
    OP_BINS,
    OP_INDEX,
    OP_READ_IDX,
    OP_UPDATE,
    OP_TMUL_HI,
    OP_TMUL_LO,
    OP_TSUM,
    OP_WALK_START,
    OP_WALK_STEP,
    OP_LARGEST,
    OP_EMPTY,
    OP_READ_BIN,
    OP_EMUL0,
    OP_EMUL1,
    OP_EADD,
    OP_ESHIFT,
    OP_PUSH
  } dp_op_t;

  // datapath status back to the controller
  typedef struct packed {
    logic       log_done;
    logic       clear_last;
    logic       walk_hit;
    logic       walk_end;
    logic       total_zero;
    logic [1:0] opcode;
  } dp_status_t;

  // bit-by-bit integer square root
  function automatic logic [63:0] isqrt64(logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bitv;
    v    = v_in;
    res  = 64'd0;
    bitv = 64'd1 << 62;
    for (int s = 0; s < 32; s++) begin
      if (bitv > v) bitv = bitv >> 2;
    end
    for (int s = 0; s < 32; s++) begin
      if (bitv != 64'd0) begin
        if (v >= res + bitv) begin
          v   = v - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
    end
    return res;
  endfunction

  // q16 value of 2^(k/64) from a chain of q30 square roots of two
  function automatic logic [16:0] pow_entry(logic [5:0] k);
    logic [63:0] roots [7];
    logic [63:0] acc;
    roots[0] = 64'd1 << 31;
    for (int j = 0; j < 6; j++) roots[j + 1] = isqrt64(roots[j] << 30);
    acc = 64'd1 << 30;
    for (int b = 0; b < 6; b++) begin
      if (k[b]) acc = (acc * roots[6 - b]) >> 30;
    end
    return 17'((acc + (64'd1 << 13)) >> 14);
  endfunction

endpackage

`default_nettype wire

### rtl/log_bucket_latency_histogram.sv
// ----------------------------------------------------------------------------
// log_bucket_latency_histogram: log-spaced latency histogram
// Records samples into log2-spaced bins and answers percentile and bin reads.
// ----------------------------------------------------------------------------
// One word is worked at a time. After reset a clearing pass zeroes the bin
// store before the first word is taken. A record runs the iterative log2
// unit (six normalize steps and one squaring per fraction bit) and the
// counter read-modify-write. The first word after a register write also
// runs two more logs, of the lowest and highest bounds. A bin read does a
// store read and a two-part bin edge product. A percentile query works out
// a target rank and walks the bins in use until the running count passes
// it. A result waits in an output register while the next word is accepted.
`default_nettype none

module log_bucket_latency_histogram import lbh_pkg::*; #(
  parameter int MAX_BUCKETS   = 1024,
  parameter int COUNT_BITS    = 32,
  parameter int LOG_FRAC_BITS = 16
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_wen,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [63:0]  cfg_wdata,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [95:0]  s_tdata,   // sample_ns, quantile, bin_index
  input  wire logic [1:0]   s_tuser,   // opcode
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [127:0]      m_tdata    // value_ns, bin_count, sample_total
);

  dp_op_t     cmd;
  dp_status_t status;

  lbh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg_wen  (cfg_wen),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  lbh_datapath #(
    .MAX_BUCKETS   (MAX_BUCKETS),
    .COUNT_BITS    (COUNT_BITS),
    .LOG_FRAC_BITS (LOG_FRAC_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cmd       (cmd),
    .status    (status),
    .out_data  (m_tdata)
  );

`ifndef SYNTH
  // a taken word makes the block busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while a word is in work");

  // the log unit is never restarted mid-run
  a_log_no_restart: assert property (@(posedge clk) disable iff (rst)
    !status.log_done |-> !(cmd == OP_LOG_LO || cmd == OP_LOG_HI || cmd == OP_LOG_C))
    else $error("log unit restarted while busy");

  // a walk cannot both hit and run off the end
  a_walk_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(status.walk_hit && status.walk_end))
    else $error("walk hit and end together");
`endif

endmodule

`default_nettype wire

### rtl/lbh_log2.sv
// ----------------------------------------------------------------------------
// lbh_log2: iterative fixed-point log2
// Normalizes in six halving shift steps, then squares a q31 mantissa once
// per fraction bit.
// ----------------------------------------------------------------------------
`default_nettype none

module lbh_log2 import lbh_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  input  wire logic [63:0]            x,
  output logic                        busy,
  output logic [FRAC_BITS+5:0]        result
);

  localparam int CW = $clog2(FRAC_BITS + 8);

  logic [63:0]          norm;
  logic [5:0]           expo;
  logic [31:0]          mant;
  logic [FRAC_BITS-1:0] frac;
  logic [CW-1:0]        cnt;
  logic [6:0]           sa;
  logic                 top_zero;
  logic [63:0]          sq;
  logic [32:0]          m2;

  // normalize step size and zero test of the top bits
  assign sa       = 7'd32 >> cnt;
  assign top_zero = (norm >> (7'd64 - sa)) == 64'd0;

  // one squaring per fraction bit
  assign sq = 64'(mant) * 64'(mant);
  assign m2 = sq[63:31];

  assign result = {expo, frac};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      norm <= (x == 64'd0) ? 64'd1 : x;
      expo <= 6'd63;
      cnt  <= '0;
      busy <= 1'b1;
    end else if (busy) begin
      if (cnt < CW'(6)) begin
        if (top_zero) begin
          norm <= norm << sa;
          expo <= expo - 6'(sa);
        end
      end else if (cnt == CW'(6)) begin
        mant <= norm[63:32];
        frac <= '0;
      end else begin
        frac <= {frac[FRAC_BITS-2:0], m2[32]};
        mant <= m2[32] ? m2[32:1] : m2[31:0];
      end
      cnt <= cnt + CW'(1);
      if (cnt == CW'(6 + FRAC_BITS)) busy <= 1'b0;
    end
  end

endmodule

`default_nettype wire

### rtl/lbh_datapath.sv
// ----------------------------------------------------------------------------
// lbh_datapath: registers, bin store and arithmetic of the histogram
// Executes one controller command per cycle: log, bin index, counter
// read-modify-write, percentile target, bin walk and bin edge product.
// ----------------------------------------------------------------------------
`default_nettype none

module lbh_datapath import lbh_pkg::*; #(
  parameter int MAX_BUCKETS   = 1024,
  parameter int COUNT_BITS    = 32,
  parameter int LOG_FRAC_BITS = 16
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_wen,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [63:0]  cfg_wdata,
  input  wire logic [95:0]  s_tdata,
  input  wire logic [1:0]   s_tuser,
  input  wire dp_op_t       cmd,
  output dp_status_t        status,
  output logic [127:0]      out_data
);

  localparam int LW = 6 + LOG_FRAC_BITS;
  localparam int AW = $clog2(MAX_BUCKETS);
  localparam int NW = $clog2(MAX_BUCKETS + 1);
  localparam int EW = (AW > 10) ? AW : 10;
  localparam int CB = COUNT_BITS;

  // configuration
  logic [63:0] lowest;
  logic [63:0] highest;
  logic [1:0]  prec;
  logic [63:0] eff_lo;
  logic [63:0] eff_hi;
  logic [2:0]  sh;

  // captured word
  logic [1:0]  opc;
  logic [63:0] sample;
  logic [16:0] quant;
  logic [9:0]  binidx;

  // derived range
  logic [LW-1:0] llo;
  logic [LW-1:0] lhi;
  logic [NW-1:0] nbins;

  // histogram state
  logic [CB-1:0] total;
  logic [63:0]   largest;
  logic [AW-1:0] idx;

  // bin store
  logic [CB-1:0] mem [MAX_BUCKETS];
  logic [CB-1:0] rdata;
  logic [AW-1:0] ra;
  logic [AW-1:0] wa;
  logic [CB-1:0] wd;
  logic          we;

  // walk
  logic [NW-1:0] wcnt;
  logic          pv;
  logic [AW-1:0] pidx;
  logic [CB:0]   acc;
  logic [CB:0]   acc_new;
  logic [CB-1:0] target;
  logic [16+CB:0] ta;
  logic [32:0]   tb;
  logic          hit;

  // edge
  logic [EW-1:0] ei;
  logic [EW-1:0] q;
  logic [5:0]    k6;
  logic [16:0]   tval;
  logic [48:0]   p0;
  logic [48:0]   p1;
  logic [80:0]   prod;
  logic [144:0]  wide;
  logic [63:0]   value;
  logic [31:0]   cnt_out;
  logic          inr;

  // log unit
  logic          log_start;
  logic          log_busy;
  logic [63:0]   log_x;
  logic [LW-1:0] log_res;

  logic [63:0]   clamped;
  logic [16:0]   qf;
  logic [CB-1:0] tm1;
  logic [LW-1:0] dd;
  logic [LW+5:0] dsh;
  logic [LW+6:0] nsum;
  logic [LW-1:0] dc;
  logic [LW+5:0] csh;
  logic [LW+5:0] nmax;
  logic [AW-1:0] bin_addr;

  logic [16:0] pow_tab [64];

  for (genvar g = 0; g < 64; g++) begin : g_pow
    assign pow_tab[g] = pow_entry(6'(g));
  end

  // effective clamps and octave shift
  assign eff_lo = (lowest == 64'd0) ? 64'd1 : lowest;
  assign eff_hi = (highest > eff_lo) ? highest : eff_lo;

  always_comb begin
    unique case (prec)
      PREC_32: sh = 3'd5;
      PREC_64: sh = 3'd6;
      default: sh = 3'd4;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      lowest  <= LOWEST_RESET;
      highest <= HIGHEST_RESET;
      prec    <= PRECISION_RESET;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_LOWEST:    lowest  <= cfg_wdata;
        REG_HIGHEST:   highest <= cfg_wdata;
        REG_PRECISION: prec    <= cfg_wdata[1:0];
        default:       ;
      endcase
    end
  end

  // log unit and its operand
  assign clamped = (sample < eff_lo) ? eff_lo : ((sample > eff_hi) ? eff_hi : sample);
  assign log_start = (cmd == OP_LOG_LO) || (cmd == OP_LOG_HI) || (cmd == OP_LOG_C);

  always_comb begin
    unique case (cmd)
      OP_LOG_LO: log_x = eff_lo;
      OP_LOG_HI: log_x = eff_hi;
      default:   log_x = clamped;
    endcase
  end

  lbh_log2 #(.FRAC_BITS(LOG_FRAC_BITS)) u_log2 (
    .clk    (clk),
    .rst    (rst),
    .start  (log_start),
    .x      (log_x),
    .busy   (log_busy),
    .result (log_res)
  );

  // bins in use and bin index
  assign dd   = lhi - llo;
  assign dsh  = ({6'd0, dd} << sh) >> LOG_FRAC_BITS;
  assign nsum = (LW+7)'(dsh) + ((LW+7)'(1) << sh) + (LW+7)'(1);
  assign dc   = log_res - llo;
  assign csh  = ({6'd0, dc} << sh) >> LOG_FRAC_BITS;
  assign nmax = (LW+6)'(nbins) - (LW+6)'(1);

  // percentile target operands
  assign qf  = (quant > Q16_ONE) ? Q16_ONE : quant;
  assign tm1 = total - CB'(1);

  // walk accumulation
  assign acc_new = ((acc + (CB+1)'(rdata)) < acc) ? '1 : acc + (CB+1)'(rdata);
  assign hit     = (cmd == OP_WALK_STEP) && pv && (acc_new > (CB+1)'(target));

  // bin edge operands
  assign q    = ei >> sh;
  assign k6   = 6'(ei[5:0] << (3'd6 - sh));
  assign tval = pow_tab[k6];
  assign wide = {64'd0, prod} << q[5:0];

  assign bin_addr = AW'(binidx);

  // store port selection
  always_comb begin
    we = 1'b0;
    wa = wcnt[AW-1:0];
    wd = '0;
    unique case (cmd)
      OP_READ_IDX: ra = idx;
      OP_READ_BIN: ra = bin_addr;
      default:     ra = wcnt[AW-1:0];
    endcase
    if (cmd == OP_CLEAR) begin
      we = 1'b1;
    end else if (cmd == OP_UPDATE) begin
      we = 1'b1;
      wa = idx;
      wd = (rdata == '1) ? rdata : rdata + CB'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rdata <= mem[ra];
  end

  // control state of the datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      wcnt    <= '0;
      pv      <= 1'b0;
      total   <= '0;
      largest <= 64'd0;
    end else begin
      unique case (cmd)
        OP_CLEAR: wcnt <= wcnt + NW'(1);
        OP_UPDATE: begin
          if (total != '1) total <= total + CB'(1);
          if (sample > largest) largest <= sample;
        end
        OP_WALK_START: begin
          wcnt <= '0;
          pv   <= 1'b0;
        end
        OP_WALK_STEP: begin
          if (wcnt < nbins) begin
            wcnt <= wcnt + NW'(1);
            pv   <= 1'b1;
          end else begin
            pv <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    unique case (cmd)
      OP_CAPTURE: begin
        opc    <= s_tuser;
        sample <= s_tdata[63:0];
        quant  <= s_tdata[80:64];
        binidx <= s_tdata[90:81];
      end
      OP_SAVE_LO: llo <= log_res;
      OP_SAVE_HI: lhi <= log_res;
      OP_BINS: nbins <= (nsum > (LW+7)'(MAX_BUCKETS)) ? NW'(MAX_BUCKETS) : NW'(nsum);
      OP_INDEX: idx <= (csh > nmax) ? AW'(nmax) : AW'(csh);
      OP_TMUL_HI: ta <= (17+CB)'(qf) * (17+CB)'(tm1 >> 16);
      OP_TMUL_LO: tb <= 33'(qf) * 33'(tm1[15:0]);
      OP_TSUM: target <= CB'(ta + (17+CB)'(tb >> 16));
      OP_WALK_START: acc <= '0;
      OP_WALK_STEP: begin
        pidx <= wcnt[AW-1:0];
        if (pv) acc <= acc_new;
        if (hit) ei <= EW'(pidx);
      end
      OP_LARGEST: begin
        value   <= largest;
        cnt_out <= 32'd0;
      end
      OP_EMPTY: begin
        value   <= 64'd0;
        cnt_out <= 32'd0;
      end
      OP_READ_BIN: begin
        ei  <= EW'(binidx);
        inr <= 32'(binidx) < 32'(MAX_BUCKETS);
      end
      OP_EMUL0: begin
        p0      <= 49'(eff_lo[31:0]) * 49'(tval);
        cnt_out <= (opc == OPC_READ && inr) ? 32'(rdata) : 32'd0;
      end
      OP_EMUL1: p1 <= 49'(eff_lo[63:32]) * 49'(tval);
      OP_EADD: prod <= 81'(p0) + (81'(p1) << 32);
      OP_ESHIFT: begin
        if (q > EW'(63) || wide[144:80] != 65'd0) value <= '1;
        else value <= wide[79:16];
      end
      OP_PUSH: out_data <= {32'(total), cnt_out, value};
      default: ;
    endcase
  end

  // status
  assign status.log_done   = !log_busy;
  assign status.clear_last = (wcnt == NW'(MAX_BUCKETS - 1));
  assign status.walk_hit   = hit;
  assign status.walk_end   = (cmd == OP_WALK_STEP) && pv && !hit &&
                             (pidx == AW'(nbins - NW'(1)));
  assign status.total_zero = (total == '0);
  assign status.opcode     = opc;

endmodule

`default_nettype wire

### rtl/lbh_ctrl.sv
// ----------------------------------------------------------------------------
// lbh_ctrl: sequencing state machine of the histogram
// Runs the clearing pass, takes one word at a time, refreshes the cached
// range after a register write and steps the datapath through each opcode.
// ----------------------------------------------------------------------------
`default_nettype none

module lbh_ctrl import lbh_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_wen,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  output logic            m_tvalid,
  input  wire logic       m_tready,
  input  wire dp_status_t status,
  output dp_op_t          cmd
);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DISPATCH,
    S_LO_GO, S_LO_WAIT, S_HI_GO, S_HI_WAIT, S_BINS,
    S_C_GO, S_C_WAIT, S_RD_IDX, S_UPDATE,
    S_TMUL_HI, S_TMUL_LO, S_TSUM, S_WALK_GO, S_WALK, S_LARGEST, S_EMPTY,
    S_RD_BIN, S_EMUL0, S_EMUL1, S_EADD, S_ESHIFT, S_FINISH
  } state_t;

  state_t state;
  state_t state_next;
  logic   dirty;
  logic   out_free;

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;

  // next state and command
  always_comb begin
    state_next = state;
    cmd        = OP_NONE;
    unique case (state)
      S_CLEAR: begin
        cmd = OP_CLEAR;
        if (status.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (s_tvalid) begin
          cmd        = OP_CAPTURE;
          state_next = dirty ? S_LO_GO : S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (status.opcode)
          OPC_RECORD: state_next = S_C_GO;
          OPC_PCTL:   state_next = status.total_zero ? S_EMPTY : S_TMUL_HI;
          OPC_READ:   state_next = S_RD_BIN;
          default:    state_next = S_IDLE;
        endcase
      end
      S_LO_GO: begin
        cmd        = OP_LOG_LO;
        state_next = S_LO_WAIT;
      end
      S_LO_WAIT: begin
        if (status.log_done) begin
          cmd        = OP_SAVE_LO;
          state_next = S_HI_GO;
        end
      end
      S_HI_GO: begin
        cmd        = OP_LOG_HI;
        state_next = S_HI_WAIT;
      end
      S_HI_WAIT: begin
        if (status.log_done) begin
          cmd        = OP_SAVE_HI;
          state_next = S_BINS;
        end
      end
      S_BINS: begin
        cmd        = OP_BINS;
        state_next = S_DISPATCH;
      end
      S_C_GO: begin
        cmd        = OP_LOG_C;
        state_next = S_C_WAIT;
      end
      S_C_WAIT: begin
        if (status.log_done) begin
          cmd        = OP_INDEX;
          state_next = S_RD_IDX;
        end
      end
      S_RD_IDX: begin
        cmd        = OP_READ_IDX;
        state_next = S_UPDATE;
      end
      S_UPDATE: begin
        cmd        = OP_UPDATE;
        state_next = S_IDLE;
      end
      S_TMUL_HI: begin
        cmd        = OP_TMUL_HI;
        state_next = S_TMUL_LO;
      end
      S_TMUL_LO: begin
        cmd        = OP_TMUL_LO;
        state_next = S_TSUM;
      end
      S_TSUM: begin
        cmd        = OP_TSUM;
        state_next = S_WALK_GO;
      end
      S_WALK_GO: begin
        cmd        = OP_WALK_START;
        state_next = S_WALK;
      end
      S_WALK: begin
        cmd = OP_WALK_STEP;
        if (status.walk_hit) state_next = S_EMUL0;
        else if (status.walk_end) state_next = S_LARGEST;
      end
      S_LARGEST: begin
        cmd        = OP_LARGEST;
        state_next = S_FINISH;
      end
      S_EMPTY: begin
        cmd        = OP_EMPTY;
        state_next = S_FINISH;
      end
      S_RD_BIN: begin
        cmd        = OP_READ_BIN;
        state_next = S_EMUL0;
      end
      S_EMUL0: begin
        cmd        = OP_EMUL0;
        state_next = S_EMUL1;
      end
      S_EMUL1: begin
        cmd        = OP_EMUL1;
        state_next = S_EADD;
      end
      S_EADD: begin
        cmd        = OP_EADD;
        state_next = S_ESHIFT;
      end
      S_ESHIFT: begin
        cmd        = OP_ESHIFT;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          cmd        = OP_PUSH;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state, range refresh flag and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      dirty    <= 1'b1;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wen) dirty <= 1'b1;
      else if (state == S_BINS) dirty <= 1'b0;
      if (state == S_FINISH && out_free) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

### test/lbh_checker.sv
// ----------------------------------------------------------------------------
// lbh_checker: scoreboard of the log bucket latency histogram
// Follows register writes and accepted words, keeps its own bin store, works
// out the expected answer of every query and compares each answer word.
// ----------------------------------------------------------------------------
`default_nettype none

module lbh_checker import lbh_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_wen,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [63:0]  cfg_wdata,
  input  wire logic         s_tvalid,
  input  wire logic         s_tready,
  input  wire logic [95:0]  s_tdata,   // sample_ns, quantile, bin_index
  input  wire logic [1:0]   s_tuser,   // opcode
  input  wire logic         m_tvalid,
  input  wire logic         m_tready,
  input  wire logic [127:0] m_tdata,   // value_ns, bin_count, sample_total
  output int                errors,
  output int                pending,
  output int                checked
);

  localparam int NBINS = 1024;

  // packed from the top bit down, so value_ns lands in the lowest bits
  typedef struct packed {
    logic [31:0] sample_total;
    logic [31:0] bin_count;
    logic [63:0] value_ns;
  } answer_t;

  // shadow registers and store
  logic [63:0] lowest_q, highest_q;
  logic [1:0]  prec_q;
  logic [31:0] hist [NBINS];
  logic [31:0] total_q;
  logic [63:0] largest_q;
  logic [16:0] pow_q16 [64];
  answer_t     answers_due [$];

  // floor square root, one result bit per pass
  function automatic logic [63:0] root_floor(logic [63:0] v);
    logic [127:0] r, trial;
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = r | (128'd1 << b);
      if (trial * trial <= {64'd0, v}) r = trial;
    end
    return r[63:0];
  endfunction

  initial begin
    logic [63:0] roots [7];
    logic [63:0] acc;
    roots[0] = 64'd1 << 31;
    for (int j = 0; j < 6; j++) roots[j + 1] = root_floor(roots[j] << 30);
    for (int k = 0; k < 64; k++) begin
      acc = 64'd1 << 30;
      for (int b = 0; b < 6; b++)
        if ((k >> b) & 1) acc = (acc * roots[6 - b]) >> 30;
      pow_q16[k] = 17'((acc + (64'd1 << 13)) >> 14);
    end
  end

  function automatic logic [63:0] base_ns();
    return (lowest_q == 0) ? 64'd1 : lowest_q;
  endfunction

  function automatic logic [63:0] top_ns();
    return (highest_q > base_ns()) ? highest_q : base_ns();
  endfunction

  function automatic int per_octave_shift();
    if (prec_q == PREC_32) return 5;
    if (prec_q == PREC_64) return 6;
    return 4;
  endfunction

  // q16 log2 by repeated squaring of a q31 mantissa
  function automatic logic [63:0] log2_q16(logic [63:0] x);
    int e;
    logic [63:0] m, frac;
    if (x == 0) x = 1;
    e = 63;
    while (!x[e]) e--;
    m = (e >= 31) ? x >> (e - 31) : x << (31 - e);
    frac = 0;
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 31;
      frac = frac << 1;
      if (m >> 32) begin
        frac = frac | 1;
        m = m >> 1;
      end
    end
    return (64'(e) << 16) | frac;
  endfunction

  function automatic logic [63:0] bins_active();
    int sh;
    logic [63:0] d, n;
    sh = per_octave_shift();
    d = log2_q16(top_ns()) - log2_q16(base_ns());
    n = ((d << sh) >> 16) + (64'd1 << sh) + 1;
    return (n > NBINS) ? NBINS : n;
  endfunction

  // lower edge of a bin, saturating at all ones
  function automatic logic [63:0] lower_edge(logic [63:0] i);
    int sh, oct;
    logic [5:0] k;
    logic [191:0] v;
    sh  = per_octave_shift();
    oct = int'(i >> sh);
    k   = 6'((i & ((64'd1 << sh) - 1)) << (6 - sh));
    v   = {128'd0, base_ns()} * {175'd0, pow_q16[k]};
    if (oct < 16) v = v >> (16 - oct);
    else v = v << (oct - 16);
    return (v[191:64] != 0) ? '1 : v[63:0];
  endfunction

  function automatic void add_sample(logic [63:0] s);
    logic [63:0] c, idx, n;
    int sh;
    sh = per_octave_shift();
    n  = bins_active();
    c  = s;
    if (c < base_ns()) c = base_ns();
    if (c > top_ns()) c = top_ns();
    idx = ((log2_q16(c) - log2_q16(base_ns())) << sh) >> 16;
    if (idx > n - 1) idx = n - 1;
    if (hist[idx] != '1) hist[idx]++;
    if (total_q != '1) total_q++;
    if (s > largest_q) largest_q = s;
  endfunction

  function automatic logic [63:0] rank_value(logic [16:0] qf_in);
    logic [63:0] qf, t, target, run, n;
    if (total_q == 0) return 0;
    qf = (qf_in > Q16_ONE) ? 64'(Q16_ONE) : 64'(qf_in);
    t = 64'(total_q) - 1;
    target = qf * (t >> 16) + ((qf * (t & 64'hFFFF)) >> 16);
    n = bins_active();
    run = 0;
    for (int i = 0; i < n; i++) begin
      run = (run > ~64'd0 - hist[i]) ? ~64'd0 : run + hist[i];
      if (run > target) return lower_edge(i);
    end
    return largest_q;
  endfunction

  assign pending = answers_due.size();

  always @(posedge clk) begin
    answer_t a, got;
    if (rst) begin
      lowest_q  <= LOWEST_RESET;
      highest_q <= HIGHEST_RESET;
      prec_q    <= PRECISION_RESET;
      for (int i = 0; i < NBINS; i++) hist[i] = 0;
      total_q   = 0;
      largest_q = 0;
      answers_due.delete();
      errors  <= 0;
      checked <= 0;
    end else begin
      // register writes
      if (cfg_wen) begin
        case (cfg_index)
          REG_LOWEST:    lowest_q  <= cfg_wdata;
          REG_HIGHEST:   highest_q <= cfg_wdata;
          REG_PRECISION: prec_q    <= cfg_wdata[1:0];
          default: ;
        endcase
      end
      // accepted input word
      if (s_tvalid && s_tready) begin
        case (s_tuser)
          OPC_RECORD: add_sample(s_tdata[63:0]);
          OPC_PCTL: begin
            a.value_ns     = rank_value(s_tdata[80:64]);
            a.bin_count    = 0;
            a.sample_total = total_q;
            answers_due.push_back(a);
          end
          OPC_READ: begin
            a.value_ns     = lower_edge(64'(s_tdata[90:81]));
            a.bin_count    = hist[s_tdata[90:81]];
            a.sample_total = total_q;
            answers_due.push_back(a);
          end
          default: ;
        endcase
      end
      // accepted answer word
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (answers_due.size() == 0) begin
          $display("%0t: unexpected answer word %h", $time, m_tdata);
          errors <= errors + 1;
        end else begin
          a = answers_due.pop_front();
          checked <= checked + 1;
          if (got != a) begin
            $display("%0t: mismatch value_ns exp %h got %h, bin_count exp %0d got %0d,",
                     $time, a.value_ns, got.value_ns, a.bin_count, got.bin_count);
            $display("  sample_total exp %0d got %0d", a.sample_total, got.sample_total);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

### test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: regression bench of the log bucket latency histogram
// Drives directed and random records, percentile queries and bin reads
// through several register settings with random stalls on both streams.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import lbh_pkg::*;

  localparam logic [1:0] OPC_UNUSED = 2'd3;
  localparam int         STALL_LIMIT = 20000;

  logic         clk = 0;
  logic         rst = 1;
  logic         cfg_wen = 0;
  logic [1:0]   cfg_index = '0;
  logic [63:0]  cfg_wdata = '0;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [95:0]  s_tdata = '0;   // sample_ns, quantile, bin_index
  logic [1:0]   s_tuser = '0;   // opcode
  logic         m_tvalid;
  logic         m_tready = 0;
  logic [127:0] m_tdata;        // value_ns, bin_count, sample_total
  logic         idle_on = 1;
  int           errors, pending, checked, words_sent, quiet_cycles;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  log_bucket_latency_histogram DUT (.*);

  lbh_checker u_checker (.*);

  // answer side back-pressure
  always @(negedge clk)
    m_tready <= rst ? 1'b0 : (!idle_on || $urandom_range(99) >= 22);

  // stall watchdog
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("log_bucket_latency_histogram regression: fail");
      $finish;
    end
  end

  // one input word, held until taken
  task automatic send_word(logic [1:0] op, logic [63:0] sample, logic [16:0] qf,
                           logic [9:0] bin);
    while (idle_on && $urandom_range(99) < 22) begin
      s_tvalid <= 0;
      @(negedge clk);
    end
    s_tvalid <= 1;
    s_tuser  <= op;
    s_tdata  <= {5'd0, bin, qf, sample};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    words_sent++;
    @(negedge clk);
  endtask

  // wait for all answers and the tail of any record, then write
  task automatic write_reg(logic [1:0] idx, logic [63:0] val);
    s_tvalid <= 0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (120) @(negedge clk);
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    cfg_wen   <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_wen <= 0;
    @(negedge clk);
  endtask

  task automatic set_range(logic [63:0] lo, logic [63:0] hi, logic [1:0] prec);
    write_reg(REG_LOWEST, lo);
    write_reg(REG_HIGHEST, hi);
    write_reg(REG_PRECISION, prec);
  endtask

  // random mix, mostly records near the configured range
  task automatic random_words(int count, logic [63:0] lo, logic [63:0] hi);
    int r;
    logic [63:0] s;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      case ($urandom_range(3))
        0: s = {$urandom, $urandom};
        1: s = 64'($urandom_range(2000));
        default: s = lo + ((hi > lo) ? ({$urandom, $urandom} % (hi - lo + 1)) : 0);
      endcase
      if (r < 60) send_word(OPC_RECORD, s, 17'($urandom), 10'($urandom));
      else if (r < 78)
        send_word(OPC_PCTL, {$urandom, $urandom},
                  ($urandom_range(4) == 0) ? 17'($urandom) : 17'($urandom_range(65536)),
                  10'($urandom));
      else if (r < 96) send_word(OPC_READ, {$urandom, $urandom}, 17'($urandom),
                                 ($urandom_range(1) == 0) ? 10'($urandom_range(80)) :
                                 10'($urandom));
      else send_word(OPC_UNUSED, {$urandom, $urandom}, 17'($urandom), 10'($urandom));
    end
  endtask

  initial begin
    words_sent = 0;
    repeat (7) @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // directed part at reset settings
    send_word(OPC_PCTL, 0, 17'd32768, 0);
    send_word(OPC_READ, 0, 0, 10'd0);
    send_word(OPC_RECORD, 64'd0, 0, 0);
    send_word(OPC_RECORD, 64'd1, 0, 0);
    send_word(OPC_RECORD, 64'd500, 0, 0);
    send_word(OPC_RECORD, 64'd1000000, 0, 0);
    send_word(OPC_RECORD, '1, 0, 0);
    send_word(OPC_UNUSED, '1, '1, '1);
    send_word(OPC_READ, 0, 0, 10'd0);
    send_word(OPC_READ, 0, 0, 10'd143);
    send_word(OPC_READ, 0, 0, 10'd1023);
    send_word(OPC_READ, 0, 0, 10'd16);
    send_word(OPC_PCTL, 0, 17'd0, 0);
    send_word(OPC_PCTL, 0, 17'd65536, 0);
    send_word(OPC_PCTL, 0, 17'h1FFFF, 0);
    send_word(OPC_PCTL, 0, 17'd32768, 0);
    send_word(OPC_RECORD, 64'd7, 0, 0);
    send_word(OPC_PCTL, 0, 17'd49152, 0);
    random_words(180, 64'd1, 64'd1000000);

    // wide range, 32 per octave
    set_range(64'd1000, 64'd1000000000, PREC_32);
    random_words(190, 64'd1000, 64'd1000000000);

    // zero lower and upper, 64 per octave, no idling
    idle_on = 0;
    set_range(64'd0, 64'd0, PREC_64);
    random_words(190, 64'd0, 64'd3);
    idle_on = 1;

    // saturated edges
    set_range('1, '1, 2'd0);
    send_word(OPC_READ, 0, 0, 10'd1023);
    random_words(180, 64'hFFFF_FFFF_FFFF_0000, '1);

    // full range, capped bin count
    set_range(64'd1, '1, PREC_64);
    send_word(OPC_PCTL, 0, 17'd65536, 0);
    random_words(190, 64'd1, 64'd100000000);

    // narrow range
    set_range(64'd37, 64'd50000, 2'd1);
    random_words(190, 64'd37, 64'd50000);

    s_tvalid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    $display("covered %0d input words over six register settings, %0d answers checked",
             words_sent, checked);
    if (errors == 0) $display("log_bucket_latency_histogram regression: pass");
    else $display("log_bucket_latency_histogram regression: fail");
    $finish;
  end

endmodule

`default_nettype wire
